// ===== rtl/cfd_pkg.sv =====
// shared types, constants and crc function for the crc16 frame deframer
package cfd_pkg;

    localparam int unsigned MAX_PAYLOAD    = 1024;
    localparam int unsigned FRAME_OVERHEAD = 10;
    localparam int unsigned FIFO_DEPTH     = 2;
    localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [10:0] COUNT_MAX = 11'h7FF;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TOO_SHORT = 2'd1,
        STATUS_TOO_LONG  = 2'd2,
        STATUS_BAD_CRC   = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        logic [11:0] size;
        logic [15:0] command;
        logic [15:0] length;
        logic [15:0] crc_calc;
        logic [15:0] crc_rx;
        logic [31:0] reserve;
    } entry_t;

    // reflected crc16 modbus, one byte
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/cfd_front.sv =====
// front part: byte counting, field capture, running crc and item classification
module cfd_front
    import cfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       fifo_full,
    output logic       push,
    output entry_t     push_entry
);

    logic [10:0] count_reg,   count_next;
    logic [15:0] crc_reg,     crc_next;
    logic [15:0] command_reg, command_next;
    logic [15:0] length_reg,  length_next;
    logic [39:0] hist_reg,    hist_next;
    logic        accept;
    logic        in_payload;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && !fifo_full;

    always_comb
    begin
        command_next = command_reg;
        length_next  = length_reg;
        case (count_reg)
            11'd0:   command_next[7:0]  = data_byte;
            11'd1:   command_next[15:8] = data_byte;
            11'd2:   length_next[7:0]   = data_byte;
            11'd3:   length_next[15:8]  = data_byte;
            default: ;
        endcase
    end

    // crc trails the newest byte by two, so the received crc stays out of it
    assign crc_next  = (count_reg >= 11'd2) ? crc16_update(crc_reg, hist_reg[15:8]) : crc_reg;
    assign hist_next = {hist_reg[31:0], data_byte};

    assign in_payload = (count_reg >= 11'd4) &&
                        ({6'd0, count_reg} < (17'd4 + {1'b0, length_next}));

    always_comb
    begin
        push_entry.kind     = last_byte ? KIND_STATUS : KIND_PAYLOAD;
        push_entry.data     = data_byte;
        push_entry.size     = {1'b0, count_reg} + 12'd1;
        push_entry.command  = command_next;
        push_entry.length   = length_next;
        push_entry.crc_calc = crc_next;
        push_entry.crc_rx   = {data_byte, hist_reg[7:0]};
        push_entry.reserve  = {hist_reg[15:8], hist_reg[23:16],
                               hist_reg[31:24], hist_reg[39:32]};
    end

    assign push = accept && (last_byte || in_payload);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= CRC_INIT;
            command_reg <= '0;
            length_reg  <= '0;
            hist_reg    <= '0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg   <= '0;
                crc_reg     <= CRC_INIT;
                command_reg <= '0;
                length_reg  <= '0;
                hist_reg    <= '0;
            end
            else
            begin
                if (count_reg < COUNT_MAX)
                begin
                    count_reg <= count_reg + 11'd1;
                end
                crc_reg     <= crc_next;
                command_reg <= command_next;
                length_reg  <= length_next;
                hist_reg    <= hist_next;
            end
        end
    end

endmodule

// ===== rtl/cfd_fifo.sv =====
// short queue between the front and back parts
module cfd_fifo
    import cfd_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   full,
    output logic   empty
);

    entry_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full      = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/cfd_back.sv =====
// back part: frame status checks and the registered result stage
module cfd_back
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fifo_empty,
    input  entry_t      pop_entry,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  status,
    output logic [15:0] command,
    output logic [15:0] payload_length,
    output logic [31:0] reserve_word
);

    logic        valid_reg;
    logic        kind_reg;
    logic [7:0]  payload_byte_reg;
    logic [1:0]  status_reg;
    logic [15:0] command_reg;
    logic [15:0] length_reg;
    logic [31:0] reserve_reg;
    status_t     status_calc;
    logic [16:0] expected;
    logic [16:0] size_wide;

    assign pop = !fifo_empty && (!valid_reg || out_ready);

    assign expected  = 17'(FRAME_OVERHEAD) + {1'b0, pop_entry.length};
    assign size_wide = {5'd0, pop_entry.size};

    // checks in priority order
    always_comb
    begin
        if (pop_entry.size < 12'(FRAME_OVERHEAD))
        begin
            status_calc = STATUS_TOO_SHORT;
        end
        else if (pop_entry.length > 16'(MAX_PAYLOAD))
        begin
            status_calc = STATUS_TOO_LONG;
        end
        else if (size_wide < expected)
        begin
            status_calc = STATUS_TOO_SHORT;
        end
        else if (size_wide > expected)
        begin
            status_calc = STATUS_TOO_LONG;
        end
        else if (pop_entry.crc_rx != pop_entry.crc_calc)
        begin
            status_calc = STATUS_BAD_CRC;
        end
        else
        begin
            status_calc = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= pop_entry.kind;
            if (pop_entry.kind == KIND_PAYLOAD)
            begin
                payload_byte_reg <= pop_entry.data;
                status_reg       <= STATUS_OK;
                command_reg      <= '0;
                length_reg       <= '0;
                reserve_reg      <= '0;
            end
            else
            begin
                payload_byte_reg <= '0;
                status_reg       <= status_calc;
                if (status_calc == STATUS_OK)
                begin
                    command_reg <= pop_entry.command;
                    length_reg  <= pop_entry.length;
                    reserve_reg <= pop_entry.reserve;
                end
                else
                begin
                    command_reg <= '0;
                    length_reg  <= '0;
                    reserve_reg <= '0;
                end
            end
        end
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign payload_byte   = payload_byte_reg;
    assign status         = status_reg;
    assign command        = command_reg;
    assign payload_length = length_reg;
    assign reserve_word   = reserve_reg;

endmodule

// ===== rtl/crc16_frame_deframer_top.sv =====
// top level of the crc16 frame deframer
// Takes one frame byte per transfer and sustains one byte per clock while the queue is
// not full. Payload bytes come out tentatively, passing through the two-entry queue and
// then the output register; the frame's last byte yields a status transfer along the
// same path, carrying command, length and reserve when the status is ok.
// The bytewise crc update and the counters run in the front part; the back part does
// the status checks. in_ready drops only when the queue holds two results that the
// output side has not taken. Bytes that give no result (header, reserve, crc) are
// absorbed without an output transfer.
module crc16_frame_deframer_top
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic [1:0]  status,
    output logic [15:0] command,
    output logic [15:0] payload_length,
    output logic [31:0] reserve_word
);

    entry_t push_entry;
    entry_t pop_entry;
    logic   push;
    logic   pop;
    logic   fifo_full;
    logic   fifo_empty;

    cfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_entry (push_entry)
    );

    cfd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    cfd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_empty     (fifo_empty),
        .pop_entry      (pop_entry),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .command        (command),
        .payload_length (payload_length),
        .reserve_word   (reserve_word)
    );

endmodule

// ===== tb/cfd_result_checker.sv =====
// checker for the crc16 frame deframer: predicts each result from the input transfers
module cfd_result_checker
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [7:0]  payload_byte,
    input  logic [1:0]  status,
    input  logic [15:0] command,
    input  logic [15:0] payload_length,
    input  logic [31:0] reserve_word,
    output int          fail_count,
    output int          results_waiting,
    output int          payload_seen,
    output int          status_seen,
    output int          ok_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data;
        status_t     stat;
        logic [15:0] cmd;
        logic [15:0] len;
        logic [31:0] rsv;
    } deframed_t;

    deframed_t   deframed_q[$];
    deframed_t   got;
    deframed_t   want;

    logic [10:0] frame_pos;
    logic [15:0] crc_acc;
    logic [15:0] cmd_hold;
    logic [15:0] len_hold;
    logic [47:0] recent;

    function automatic logic [15:0] crc_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0]  b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        repeat (8)
        begin
            if (r[0])
                r = {1'b0, r[15:1]} ^ CRC_POLY;
            else
                r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    task automatic clear_frame();
        frame_pos = '0;
        crc_acc   = CRC_INIT;
        cmd_hold  = '0;
        len_hold  = '0;
        recent    = '0;
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic lst);
        deframed_t   r;
        int unsigned size;
        int unsigned full_size;
        status_t     st;
        r = '0;
        recent = {recent[39:0], b};
        // the crc trails the newest byte by two so the received crc is never folded in
        if (frame_pos >= 11'd2)
            crc_acc = crc_modbus_step(crc_acc, recent[23:16]);
        case (frame_pos)
            11'd0: cmd_hold[7:0]  = b;
            11'd1: cmd_hold[15:8] = b;
            11'd2: len_hold[7:0]  = b;
            11'd3: len_hold[15:8] = b;
            default: ;
        endcase
        if (!lst)
        begin
            if (frame_pos >= 11'd4 && int'(frame_pos) < 4 + int'(len_hold))
            begin
                r.kind = KIND_PAYLOAD;
                r.data = b;
                deframed_q.push_back(r);
            end
            if (frame_pos != COUNT_MAX)
                frame_pos = frame_pos + 11'd1;
        end
        else
        begin
            size      = int'(frame_pos) + 1;
            full_size = FRAME_OVERHEAD + int'(len_hold);
            if (size < FRAME_OVERHEAD)
                st = STATUS_TOO_SHORT;
            else if (int'(len_hold) > int'(MAX_PAYLOAD))
                st = STATUS_TOO_LONG;
            else if (size < full_size)
                st = STATUS_TOO_SHORT;
            else if (size > full_size)
                st = STATUS_TOO_LONG;
            else if ({recent[7:0], recent[15:8]} != crc_acc)
                st = STATUS_BAD_CRC;
            else
                st = STATUS_OK;
            r.kind = KIND_STATUS;
            r.stat = st;
            if (st == STATUS_OK)
            begin
                r.cmd = cmd_hold;
                r.len = len_hold;
                r.rsv = {recent[23:16], recent[31:24], recent[39:32], recent[47:40]};
            end
            deframed_q.push_back(r);
            clear_frame();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deframed_q.delete();
            clear_frame();
            fail_count      = 0;
            results_waiting = 0;
            payload_seen    = 0;
            status_seen     = 0;
            ok_seen         = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                deframe_byte(data_byte, last_byte);
            if (out_valid && out_ready)
            begin
                got.kind = kind_t'(kind);
                got.data = payload_byte;
                got.stat = status_t'(status);
                got.cmd  = command;
                got.len  = payload_length;
                got.rsv  = reserve_word;
                if (deframed_q.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display({"%0t: result transfer with nothing pending: ",
                                  "kind=%0d byte=%02h status=%0d"},
                                 $realtime, got.kind, got.data, got.stat);
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count = fail_count + 1;
                        if (fail_count <= 10)
                        begin
                            $display({"%0t: mismatch, expected kind=%0d byte=%02h ",
                                      "status=%0d cmd=%04h len=%04h rsv=%08h"},
                                     $realtime, want.kind, want.data, want.stat,
                                     want.cmd, want.len, want.rsv);
                            $display({"%0t:           actual kind=%0d byte=%02h ",
                                      "status=%0d cmd=%04h len=%04h rsv=%08h"},
                                     $realtime, got.kind, got.data, got.stat,
                                     got.cmd, got.len, got.rsv);
                        end
                    end
                    if (want.kind == KIND_STATUS)
                    begin
                        status_seen = status_seen + 1;
                        if (want.stat == STATUS_OK)
                            ok_seen = ok_seen + 1;
                    end
                    else
                        payload_seen = payload_seen + 1;
                end
            end
            results_waiting = deframed_q.size();
        end
    end

endmodule

// ===== tb/tb_crc16_frame_deframer_top.sv =====
// testbench top for the crc16 frame deframer: clock, reset, frame stimulus and verdict
module tb_crc16_frame_deframer_top;
    import cfd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BYTES = 165;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [15:0] command;
    logic [15:0] payload_length;
    logic [31:0] reserve_word;

    int fail_count;
    int results_waiting;
    int payload_seen;
    int status_seen;
    int ok_seen;

    int send_idle_pct = 35;
    int recv_idle_pct = 48;
    int frames_sent = 0;
    int bytes_sent = 0;
    int cycle_cnt = 0;
    int drain_cnt;

    logic [7:0] frame_bytes[$];

    crc16_frame_deframer_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .payload_byte   (payload_byte),
        .status         (status),
        .command        (command),
        .payload_length (payload_length),
        .reserve_word   (reserve_word)
    );

    cfd_result_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .payload_byte    (payload_byte),
        .status          (status),
        .command         (command),
        .payload_length  (payload_length),
        .reserve_word    (reserve_word),
        .fail_count      (fail_count),
        .results_waiting (results_waiting),
        .payload_seen    (payload_seen),
        .status_seen     (status_seen),
        .ok_seen         (ok_seen)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("crc16_frame_deframer_top test failed");
        $finish;
    end

    // crc16 modbus over everything currently in the frame buffer
    function automatic logic [15:0] frame_crc();
        logic [15:0] c;
        int          i;
        int          k;
        c = CRC_INIT;
        for (i = 0; i < frame_bytes.size(); i++)
        begin
            c[7:0] = c[7:0] ^ frame_bytes[i];
            for (k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic lst);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    task automatic build_good(input logic [15:0] cmd, input logic [15:0] len,
                              input logic [31:0] rsv);
        logic [15:0] crc;
        int          i;
        frame_bytes.delete();
        frame_bytes.push_back(cmd[7:0]);
        frame_bytes.push_back(cmd[15:8]);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        for (i = 0; i < int'(len); i++)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(rsv[7:0]);
        frame_bytes.push_back(rsv[15:8]);
        frame_bytes.push_back(rsv[23:16]);
        frame_bytes.push_back(rsv[31:24]);
        crc = frame_crc();
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    task automatic random_frame();
        int          sel;
        int          cut;
        int          pos;
        int          i;
        logic [15:0] len;
        sel = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 40))
                                          : 16'($urandom_range(0, 12));
        build_good(16'($urandom), len, $urandom);
        if (sel < 55)
        begin
        end
        else if (sel < 65)
        begin
            // corrupt payload, reserve or crc so that only the crc check catches it
            pos = $urandom_range(4, frame_bytes.size() - 1);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
        else if (sel < 75)
        begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
            while (frame_bytes.size() > cut)
                void'(frame_bytes.pop_back());
        end
        else if (sel < 83)
        begin
            cut = $urandom_range(1, 4);
            for (i = 0; i < cut; i++)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (sel < 90)
        begin
            len = 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
            frame_bytes[2] = len[7:0];
            frame_bytes[3] = len[15:8];
        end
        else
        begin
            frame_bytes.delete();
            cut = $urandom_range(1, 14);
            for (i = 0; i < cut; i++)
                frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_phase(input int sender_idle, input int receiver_idle);
        int start;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES)
        begin
            random_frame();
            send_frame();
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // good frame with all-ones command and reserve
        build_good(16'hFFFF, 16'd1, 32'hFFFF_FFFF);
        send_frame();
        // a one-byte frame
        frame_bytes.delete();
        frame_bytes.push_back(8'h00);
        send_frame();
        // frame ends where a payload byte was due
        frame_bytes.delete();
        frame_bytes.push_back(8'h5A);
        frame_bytes.push_back(8'hA5);
        frame_bytes.push_back(8'h03);
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h00);
        send_frame();
        // crc broken in its upper byte
        build_good(16'h0000, 16'd0, 32'h0000_0000);
        frame_bytes[9] = ~frame_bytes[9];
        send_frame();

        run_phase(35, 48);
        run_phase(48, 35);
        run_phase(0, 0);

        // length field at the largest accepted value, frame cut short
        build_good(16'($urandom), 16'd2, $urandom);
        frame_bytes[2] = 8'(MAX_PAYLOAD);
        frame_bytes[3] = 8'(MAX_PAYLOAD >> 8);
        send_frame();
        // length field one above it, frame cut short
        build_good(16'($urandom), 16'd2, $urandom);
        frame_bytes[2] = 8'(MAX_PAYLOAD + 1);
        frame_bytes[3] = 8'((MAX_PAYLOAD + 1) >> 8);
        send_frame();

        @(negedge clk);
        in_valid <= 1'b0;

        drain_cnt = 0;
        while (results_waiting != 0 && drain_cnt < 20000)
        begin
            @(posedge clk);
            drain_cnt++;
        end
        repeat (16) @(posedge clk);

        if (results_waiting != 0)
            $display("%0d expected results never arrived", results_waiting);
        $display("sent %0d frames (%0d bytes) under three idle mixes, good and broken alike",
                 frames_sent, bytes_sent);
        $display("checked %0d payload transfers and %0d status transfers, %0d of them ok",
                 payload_seen, status_seen, ok_seen);
        if (fail_count == 0 && results_waiting == 0)
            $display("crc16_frame_deframer_top test passed");
        else
            $display("crc16_frame_deframer_top test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/cfd_pkg.sv
rtl/cfd_front.sv
rtl/cfd_fifo.sv
rtl/cfd_back.sv
rtl/crc16_frame_deframer_top.sv
tb/cfd_result_checker.sv
tb/tb_crc16_frame_deframer_top.sv
